@@ hdl/dts_pkg.sv @@
// Shared types and constants for the daily time switch with override modes.
// Used by the channel interfaces and by the top level; depends on nothing.
`default_nettype none

package dts_pkg;

    localparam int CHANNELS        = 3;
    localparam int ENTRY_SLOTS     = 2;
    localparam int ENTRY_W         = 18;
    localparam int DAY_W           = 17;
    localparam int TIMEOUT_W       = 17;
    localparam int NOW_W           = 32;
    localparam int FUNC_W          = 2;
    localparam int REG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 18;
    localparam int DEFAULT_ENTRIES = 2;
    localparam int DEFAULT_STAMP_W = 32;

    localparam int CH_LIGHT  = 0;
    localparam int CH_CO2    = 1;
    localparam int CH_FILTER = 2;

    // Register map: two entry slots per channel from the base, then the timeouts.
    localparam logic [REG_IDX_W-1:0] REG_ENTRY_BASE          = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FEEDING_TIMEOUT     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_MAINTENANCE_TIMEOUT = 3'd7;

    localparam logic [ENTRY_W-1:0] ENTRY_RESET [CHANNELS][ENTRY_SLOTS] = '{
        '{18'd50401, 18'd158400},
        '{18'd39601, 18'd147600},
        '{18'd1,     18'd1}
    };

    localparam logic [TIMEOUT_W-1:0] FEEDING_TIMEOUT_RESET     = 17'd900;
    localparam logic [TIMEOUT_W-1:0] MAINTENANCE_TIMEOUT_RESET = 17'd7200;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK        = 2'd0,
        FUNC_FEEDING     = 2'd1,
        FUNC_MAINTENANCE = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        MODE_SCHEDULE    = 2'd0,
        MODE_FEEDING     = 2'd1,
        MODE_MAINTENANCE = 2'd2
    } mode_t;

endpackage

`default_nettype wire

@@ hdl/dts_ifs.sv @@
// Valid/ready channel interfaces for the command words and the status words.
// Depends on dts_pkg for the field widths.
`default_nettype none

interface dts_req_if import dts_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [DAY_W-1:0]     day_seconds;
    logic [NOW_W-1:0]     now_seconds;

    modport source (output valid, output func, output day_seconds, output now_seconds,
                    input ready);
    modport sink   (input valid, input func, input day_seconds, input now_seconds,
                    output ready);
endinterface

interface dts_rsp_if import dts_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 light_on;
    logic                 co2_on;
    logic                 filter_on;
    logic [1:0]           mode;
    logic [TIMEOUT_W-1:0] remaining;

    modport source (output valid, output light_on, output co2_on, output filter_on,
                    output mode, output remaining, input ready);
    modport sink   (input valid, input light_on, input co2_on, input filter_on,
                    input mode, input remaining, output ready);
endinterface

`default_nettype wire

@@ hdl/daily_time_switch_with_overrides_top.sv @@
// Top level of the three-channel daily time switch with feeding and maintenance overrides.
// Depends on dts_pkg and on the channel interfaces in dts_ifs.sv.
`default_nettype none

// A command word is taken into an input register, evaluated in one pass of short compare
// and subtract logic; its status word moves into the result register as soon as that register
// is free or read on rsp, so every word gives exactly one status word. One word is accepted
// every clock while rsp keeps up; the input register can still take a word while a status
// word waits, and the block stalls only when both registers are full. Configuration writes
// take effect at the clock edge of the write and should be made while no word is in flight.
module daily_time_switch_with_overrides_top
    import dts_pkg::*;
#(
    parameter int ENTRIES_PER_CHANNEL = DEFAULT_ENTRIES,
    parameter int STAMP_WIDTH         = DEFAULT_STAMP_W
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    dts_req_if.sink                    req,
    dts_rsp_if.source                  rsp,
    input  wire logic                  cfg_we,
    input  wire logic [REG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers.
    logic [ENTRY_W-1:0]   entry_reg [CHANNELS][ENTRIES_PER_CHANNEL];
    logic [TIMEOUT_W-1:0] feed_to_reg;
    logic [TIMEOUT_W-1:0] maint_to_reg;

    // Input register.
    logic                 s1_valid_reg;
    logic [FUNC_W-1:0]    s1_func_reg;
    logic [DAY_W-1:0]     s1_day_reg;
    logic [NOW_W-1:0]     s1_now_reg;

    // Switch state.
    logic                   light_reg, co2_reg, filter_reg;
    logic                   feed_act_reg, maint_act_reg;
    logic [STAMP_WIDTH-1:0] feed_start_reg, maint_start_reg;

    logic                   light_next, co2_next, filter_next;
    logic                   feed_act_next, maint_act_next;
    logic [STAMP_WIDTH-1:0] feed_start_next, maint_start_next;

    // Result register.
    logic                 out_valid_reg;
    logic                 out_light_reg, out_co2_reg, out_filter_reg;
    mode_t                out_mode_reg;
    logic [TIMEOUT_W-1:0] out_rem_reg;

    mode_t                mode_next;
    logic [TIMEOUT_W-1:0] rem_next;

    logic                   advance;
    logic                   fire;
    logic [STAMP_WIDTH-1:0] now_s;
    logic [CHANNELS-1:0]    sched;
    logic [STAMP_WIDTH-1:0] feed_elapsed, maint_elapsed;
    logic                   feed_expired, maint_expired;
    logic [TIMEOUT_W-1:0]   feed_left, maint_left;

    assign advance   = !out_valid_reg || rsp.ready;
    assign fire      = s1_valid_reg && advance;
    assign req.ready = !s1_valid_reg || advance;

    generate
        if (STAMP_WIDTH > NOW_W) begin : g_now_wide
            assign now_s = {{(STAMP_WIDTH - NOW_W){1'b0}}, s1_now_reg};
        end else if (STAMP_WIDTH == NOW_W) begin : g_now_same
            assign now_s = s1_now_reg;
        end else begin : g_now_narrow
            assign now_s = s1_now_reg[STAMP_WIDTH-1:0];
        end
    endgenerate

    // Schedule lookup. Before the first entry or at and after the last one, the last
    // entry's state holds; between them the first entry's state holds.
    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            if ((s1_day_reg < entry_reg[ch][0][ENTRY_W-1:1])
                || (s1_day_reg >= entry_reg[ch][ENTRIES_PER_CHANNEL-1][ENTRY_W-1:1]))
            begin
                sched[ch] = entry_reg[ch][ENTRIES_PER_CHANNEL-1][0];
            end
            else
            begin
                sched[ch] = entry_reg[ch][0][0];
            end
        end
    end

    // Next switch state for the word in the input register.
    always_comb
    begin
        light_next       = light_reg;
        co2_next         = co2_reg;
        filter_next      = filter_reg;
        feed_act_next    = feed_act_reg;
        maint_act_next   = maint_act_reg;
        feed_start_next  = feed_start_reg;
        maint_start_next = maint_start_reg;
        unique case (s1_func_reg)
            FUNC_TICK:
            begin
                if (feed_act_reg)
                begin
                    if (feed_expired)
                    begin
                        feed_act_next = 1'b0;
                    end
                end
                else if (maint_act_reg)
                begin
                    if (maint_expired)
                    begin
                        maint_act_next = 1'b0;
                    end
                end
                else
                begin
                    light_next  = sched[CH_LIGHT];
                    co2_next    = sched[CH_CO2];
                    filter_next = sched[CH_FILTER];
                end
            end
            FUNC_FEEDING:
            begin
                if (!maint_act_reg)
                begin
                    feed_act_next = !feed_act_reg;
                    if (!feed_act_reg)
                    begin
                        feed_start_next = now_s;
                        light_next      = 1'b1;
                        co2_next        = 1'b0;
                        filter_next     = 1'b0;
                    end
                end
            end
            FUNC_MAINTENANCE:
            begin
                if (!feed_act_reg)
                begin
                    maint_act_next = !maint_act_reg;
                    if (!maint_act_reg)
                    begin
                        maint_start_next = now_s;
                        light_next       = 1'b1;
                        co2_next         = 1'b0;
                        filter_next      = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // The elapsed time of a running override is taken from its stored start stamp. A mode
    // that is only now being entered starts at this word's stamp, so its full timeout is left.
    assign feed_elapsed  = now_s - feed_start_reg;
    assign maint_elapsed = now_s - maint_start_reg;
    assign feed_expired  = feed_elapsed >= STAMP_WIDTH'(feed_to_reg);
    assign maint_expired = maint_elapsed >= STAMP_WIDTH'(maint_to_reg);
    assign feed_left     = !feed_act_reg ? feed_to_reg :
                           feed_expired ? '0 : feed_to_reg - feed_elapsed[TIMEOUT_W-1:0];
    assign maint_left    = !maint_act_reg ? maint_to_reg :
                           maint_expired ? '0 : maint_to_reg - maint_elapsed[TIMEOUT_W-1:0];

    always_comb
    begin
        priority if (feed_act_next)
        begin
            mode_next = MODE_FEEDING;
            rem_next  = feed_left;
        end
        else if (maint_act_next)
        begin
            mode_next = MODE_MAINTENANCE;
            rem_next  = maint_left;
        end
        else
        begin
            mode_next = MODE_SCHEDULE;
            rem_next  = '0;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                for (int e = 0; e < ENTRIES_PER_CHANNEL; e++)
                begin
                    entry_reg[ch][e] <= ENTRY_RESET[ch][e];
                end
            end
            feed_to_reg  <= FEEDING_TIMEOUT_RESET;
            maint_to_reg <= MAINTENANCE_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                for (int e = 0; e < ENTRIES_PER_CHANNEL; e++)
                begin
                    if (cfg_index == REG_ENTRY_BASE + REG_IDX_W'(ch * ENTRY_SLOTS + e))
                    begin
                        entry_reg[ch][e] <= cfg_data[ENTRY_W-1:0];
                    end
                end
            end
            if (cfg_index == REG_FEEDING_TIMEOUT)
            begin
                feed_to_reg <= cfg_data[TIMEOUT_W-1:0];
            end
            if (cfg_index == REG_MAINTENANCE_TIMEOUT)
            begin
                maint_to_reg <= cfg_data[TIMEOUT_W-1:0];
            end
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_func_reg <= req.func;
            s1_day_reg  <= req.day_seconds;
            s1_now_reg  <= req.now_seconds;
        end
    end

    // Switch state, updated as a word moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg       <= 1'b0;
            co2_reg         <= 1'b0;
            filter_reg      <= 1'b0;
            feed_act_reg    <= 1'b0;
            maint_act_reg   <= 1'b0;
            feed_start_reg  <= '0;
            maint_start_reg <= '0;
        end
        else if (fire)
        begin
            light_reg       <= light_next;
            co2_reg         <= co2_next;
            filter_reg      <= filter_next;
            feed_act_reg    <= feed_act_next;
            maint_act_reg   <= maint_act_next;
            feed_start_reg  <= feed_start_next;
            maint_start_reg <= maint_start_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_light_reg  <= light_next;
            out_co2_reg    <= co2_next;
            out_filter_reg <= filter_next;
            out_mode_reg   <= mode_next;
            out_rem_reg    <= rem_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.light_on  = out_light_reg;
    assign rsp.co2_on    = out_co2_reg;
    assign rsp.filter_on = out_filter_reg;
    assign rsp.mode      = out_mode_reg;
    assign rsp.remaining = out_rem_reg;

`ifndef SYNTHESIS
    a_modes_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(feed_act_reg && maint_act_reg))
        else $error("feeding and maintenance overrides active together");

    a_override_outputs: assert property (@(posedge clk) disable iff (!rst_n)
        (feed_act_reg || maint_act_reg) |-> (light_reg && !co2_reg && !filter_reg))
        else $error("channel states not forced during an override");

    a_schedule_no_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_mode_reg == MODE_SCHEDULE) |-> (out_rem_reg == '0))
        else $error("remaining time reported in schedule mode");

    a_word_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("evaluated word did not reach the result register");
`endif

endmodule

`default_nettype wire

@@ tb/sv/daily_time_switch_with_overrides_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for daily_time_switch_with_overrides_top: a directed table,
// then random phases; status words are checked against a predictor or a fixed value.
// Depends on dts_pkg, the channel interfaces in dts_ifs.sv and the top level itself.

module daily_time_switch_with_overrides_top_test
    import dts_pkg::*;
();

    localparam int STALL_LIMIT    = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_WORDS    = 160;
    localparam int PHASES         = 7;
    localparam int MAX_REPORTS    = 40;
    localparam int DAY_LAST       = 86399;
    localparam int DAY_LENGTH     = 86400;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_LIGHT_A  = REG_ENTRY_BASE + REG_IDX_W'(2 * CH_LIGHT);
    localparam logic [REG_IDX_W-1:0] REG_LIGHT_B  = REG_LIGHT_A + 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CO2_A    = REG_ENTRY_BASE + REG_IDX_W'(2 * CH_CO2);
    localparam logic [REG_IDX_W-1:0] REG_CO2_B    = REG_CO2_A + 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FILTER_A = REG_ENTRY_BASE + REG_IDX_W'(2 * CH_FILTER);

    typedef struct packed {
        logic                 light_on;
        logic                 co2_on;
        logic                 filter_on;
        mode_t                mode;
        logic [TIMEOUT_W-1:0] remaining;
    } status_t;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    typedef enum {SET_TYPICAL, SET_SHORT, SET_EXTREME, SET_NOISE} setting_t;

    typedef struct {
        row_kind_t             kind;
        logic [FUNC_W-1:0]     func;
        logic [DAY_W-1:0]      day;
        logic [NOW_W-1:0]      now;
        logic [REG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        bit                    fixed;
        status_t               want;
    } plan_row_t;

    localparam status_t NO_STATUS    = '0;
    localparam status_t NIGHT_STATUS = '{1'b0, 1'b0, 1'b1, MODE_SCHEDULE, 17'd0};
    localparam status_t DAY_STATUS   = '{1'b1, 1'b1, 1'b1, MODE_SCHEDULE, 17'd0};
    localparam status_t FEED_STATUS  = '{1'b1, 1'b0, 1'b0, MODE_FEEDING, 17'd900};
    localparam status_t MAINT_STATUS = '{1'b1, 1'b0, 1'b0, MODE_MAINTENANCE, 17'd7200};
    localparam status_t LONG_STATUS  = '{1'b1, 1'b0, 1'b0, MODE_MAINTENANCE, 17'd86400};

    // Directed part. Rows with a fixed status are checked against that value directly.
    plan_row_t plan [26] = '{
        '{ROW_WORD, FUNC_TICK,        17'd0,      32'd0,          REG_LIGHT_A, 18'd0,
          1'b1, NIGHT_STATUS},
        '{ROW_WORD, FUNC_TICK,        17'd86399,  32'd1,          REG_LIGHT_A, 18'd0,
          1'b1, NIGHT_STATUS},
        '{ROW_WORD, FUNC_TICK,        17'd25200,  32'd2,          REG_LIGHT_A, 18'd0,
          1'b1, DAY_STATUS},
        '{ROW_WORD, FUNC_FEEDING,     17'd0,      32'hFFFF_FF00,  REG_LIGHT_A, 18'd0,
          1'b1, FEED_STATUS},
        '{ROW_WORD, FUNC_TICK,        17'd0,      32'h0000_0283,  REG_LIGHT_A, 18'd0,
          1'b0, NO_STATUS},
        '{ROW_WORD, FUNC_MAINTENANCE, 17'd0,      32'h0000_0283,  REG_LIGHT_A, 18'd0,
          1'b0, NO_STATUS},
        '{ROW_WORD, FUNC_TICK,        17'd0,      32'h0000_0284,  REG_LIGHT_A, 18'd0,
          1'b0, NO_STATUS},
        '{ROW_WORD, FUNC_MAINTENANCE, 17'd0,      32'd100,        REG_LIGHT_A, 18'd0,
          1'b1, MAINT_STATUS},
        '{ROW_WORD, FUNC_FEEDING,     17'd0,      32'd100,        REG_LIGHT_A, 18'd0,
          1'b0, NO_STATUS},
        '{ROW_WORD, FUNC_UNUSED,      17'd0,      32'd7400,       REG_LIGHT_A, 18'd0,
          1'b0, NO_STATUS},
        '{ROW_WORD, FUNC_MAINTENANCE, 17'd0,      32'd7400,       REG_LIGHT_A, 18'd0,
          1'b0, NO_STATUS},
        '{ROW_WORD, FUNC_TICK,        17'd131071, 32'd7401,       REG_LIGHT_A, 18'd0,
          1'b0, NO_STATUS},
        '{ROW_CFG,  FUNC_TICK,        17'd0,      32'd0,   REG_FEEDING_TIMEOUT, 18'd0,
          1'b0, NO_STATUS},
        '{ROW_WORD, FUNC_FEEDING,     17'd0,      32'd5,          REG_LIGHT_A, 18'd0,
          1'b0, NO_STATUS},
        '{ROW_WORD, FUNC_TICK,        17'd0,      32'd5,          REG_LIGHT_A, 18'd0,
          1'b0, NO_STATUS},
        '{ROW_CFG,  FUNC_TICK,        17'd0,      32'd0,   REG_MAINTENANCE_TIMEOUT, 18'd86400,
          1'b0, NO_STATUS},
        '{ROW_WORD, FUNC_MAINTENANCE, 17'd0,      32'd0,          REG_LIGHT_A, 18'd0,
          1'b1, LONG_STATUS},
        '{ROW_WORD, FUNC_TICK,        17'd0,      32'd86399,      REG_LIGHT_A, 18'd0,
          1'b0, NO_STATUS},
        '{ROW_WORD, FUNC_MAINTENANCE, 17'd0,      32'd86399,      REG_LIGHT_A, 18'd0,
          1'b0, NO_STATUS},
        '{ROW_CFG,  FUNC_TICK,        17'd0,      32'd0,          REG_LIGHT_A, 18'd160001,
          1'b0, NO_STATUS},
        '{ROW_CFG,  FUNC_TICK,        17'd0,      32'd0,          REG_LIGHT_B, 18'd2000,
          1'b0, NO_STATUS},
        '{ROW_CFG,  FUNC_TICK,        17'd0,      32'd0,          REG_CO2_A, 18'd0,
          1'b0, NO_STATUS},
        '{ROW_CFG,  FUNC_TICK,        17'd0,      32'd0,          REG_CO2_B, 18'h3FFFF,
          1'b0, NO_STATUS},
        '{ROW_WORD, FUNC_TICK,        17'd50000,  32'd86400,      REG_LIGHT_A, 18'd0,
          1'b0, NO_STATUS},
        '{ROW_WORD, FUNC_TICK,        17'd131071, 32'd86401,      REG_LIGHT_A, 18'd0,
          1'b0, NO_STATUS},
        '{ROW_WORD, FUNC_TICK,        17'd65536,  32'd86402,      REG_LIGHT_A, 18'd0,
          1'b0, NO_STATUS}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [REG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dts_req_if req_ch ();
    dts_rsp_if rsp_ch ();

    daily_time_switch_with_overrides_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the registers and of the switch state.
    logic [ENTRY_W-1:0]   entry_word [2 * CHANNELS];
    logic [TIMEOUT_W-1:0] feed_limit;
    logic [TIMEOUT_W-1:0] maint_limit;
    logic                 light_st;
    logic                 co2_st;
    logic                 filter_st;
    logic                 feeding_on;
    logic                 maint_on;
    logic [NOW_W-1:0]     feeding_t0;
    logic [NOW_W-1:0]     maint_t0;

    status_t     pending_status [$];
    int          error_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          holds_asked = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    function automatic logic [TIMEOUT_W-1:0] time_left(input logic [NOW_W-1:0] t0,
                                                       input logic [TIMEOUT_W-1:0] limit,
                                                       input logic [NOW_W-1:0] now);
        logic [NOW_W-1:0] elapsed;
        elapsed = now - t0;
        if (elapsed >= NOW_W'(limit))
            return '0;
        return limit - elapsed[TIMEOUT_W-1:0];
    endfunction

    // With two entries, anything outside [first, last) takes the last entry's state,
    // and anything inside it takes the first entry's state.
    function automatic logic channel_state(input logic [REG_IDX_W-1:0] base,
                                           input logic [DAY_W-1:0] day);
        logic [ENTRY_W-1:0] first_e;
        logic [ENTRY_W-1:0] last_e;
        first_e = entry_word[base];
        last_e  = entry_word[base + 3'd1];
        if (day < first_e[ENTRY_W-1:1] || day >= last_e[ENTRY_W-1:1])
            return last_e[0];
        return first_e[0];
    endfunction

    function automatic status_t step_switch(input logic [FUNC_W-1:0] f,
                                            input logic [DAY_W-1:0] day,
                                            input logic [NOW_W-1:0] now);
        status_t st;
        case (f)
            FUNC_TICK:
            begin
                if (feeding_on)
                begin
                    if (time_left(feeding_t0, feed_limit, now) == '0)
                        feeding_on = 1'b0;
                end
                else if (maint_on)
                begin
                    if (time_left(maint_t0, maint_limit, now) == '0)
                        maint_on = 1'b0;
                end
                else
                begin
                    light_st  = channel_state(REG_LIGHT_A, day);
                    co2_st    = channel_state(REG_CO2_A, day);
                    filter_st = channel_state(REG_FILTER_A, day);
                end
            end
            FUNC_FEEDING:
            begin
                if (!maint_on)
                begin
                    if (feeding_on)
                        feeding_on = 1'b0;
                    else
                    begin
                        feeding_on = 1'b1;
                        feeding_t0 = now;
                        light_st   = 1'b1;
                        co2_st     = 1'b0;
                        filter_st  = 1'b0;
                    end
                end
            end
            FUNC_MAINTENANCE:
            begin
                if (!feeding_on)
                begin
                    if (maint_on)
                        maint_on = 1'b0;
                    else
                    begin
                        maint_on  = 1'b1;
                        maint_t0  = now;
                        light_st  = 1'b1;
                        co2_st    = 1'b0;
                        filter_st = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        st.light_on  = light_st;
        st.co2_on    = co2_st;
        st.filter_on = filter_st;
        if (feeding_on)
        begin
            st.mode      = MODE_FEEDING;
            st.remaining = time_left(feeding_t0, feed_limit, now);
        end
        else if (maint_on)
        begin
            st.mode      = MODE_MAINTENANCE;
            st.remaining = time_left(maint_t0, maint_limit, now);
        end
        else
        begin
            st.mode      = MODE_SCHEDULE;
            st.remaining = '0;
        end
        return st;
    endfunction

    // Offers one command word, waits for it to be taken and records its status word.
    task automatic send_word(input logic [FUNC_W-1:0] f, input logic [DAY_W-1:0] day,
                             input logic [NOW_W-1:0] now, input bit fixed,
                             input status_t want);
        status_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.func        <= f;
        req_ch.day_seconds <= day;
        req_ch.now_seconds <= now;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        predicted = step_switch(f, day, now);
        pending_status.push_back(fixed ? want : predicted);
    endtask

    // Register writes are only made once every status word in flight has come back.
    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_status.size() != 0);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FEEDING_TIMEOUT)
            feed_limit = val[TIMEOUT_W-1:0];
        else if (idx == REG_MAINTENANCE_TIMEOUT)
            maint_limit = val[TIMEOUT_W-1:0];
        else
            entry_word[idx] = val;
    endtask

    // Status word receiver; a requested hold-off keeps ready low for a long stretch.
    initial
    begin : status_receiver
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_asked)
            begin
                hold_left = HOLD_CYCLES;
                holds_served++;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin : status_check
        status_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (pending_status.size() == 0)
                    report_mismatch("status word arrived with none outstanding");
                else
                begin
                    want = pending_status.pop_front();
                    if (rsp_ch.light_on !== want.light_on)
                        report_mismatch($sformatf("light_on got %b want %b",
                                                  rsp_ch.light_on, want.light_on));
                    if (rsp_ch.co2_on !== want.co2_on)
                        report_mismatch($sformatf("co2_on got %b want %b",
                                                  rsp_ch.co2_on, want.co2_on));
                    if (rsp_ch.filter_on !== want.filter_on)
                        report_mismatch($sformatf("filter_on got %b want %b",
                                                  rsp_ch.filter_on, want.filter_on));
                    if (rsp_ch.mode !== want.mode)
                        report_mismatch($sformatf("mode got %0d want %0d",
                                                  rsp_ch.mode, want.mode));
                    if (rsp_ch.remaining !== want.remaining)
                        report_mismatch($sformatf("remaining got %0d want %0d",
                                                  rsp_ch.remaining, want.remaining));
                end
            end
        end
    end

    // Ends the run if neither channel moves a word for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid & req_ch.ready) === 1'b1 || (rsp_ch.valid & rsp_ch.ready) === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        setting_t           setting;
        logic [ENTRY_W-1:0] ea;
        logic [ENTRY_W-1:0] eb;
        logic [NOW_W-1:0]   clock_now;
        logic [FUNC_W-1:0]  f;
        logic [DAY_W-1:0]   day;
        int                 ta;
        int                 tb_end;
        int                 tmp;
        int                 step_max;
        int unsigned        pick;

        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.func        <= FUNC_TICK;
        req_ch.day_seconds <= '0;
        req_ch.now_seconds <= '0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_ENTRY_BASE;
        cfg_data           <= '0;

        for (int ch = 0; ch < CHANNELS; ch++)
            for (int s = 0; s < ENTRY_SLOTS; s++)
                entry_word[ENTRY_SLOTS * ch + s] = ENTRY_RESET[ch][s];
        feed_limit  = FEEDING_TIMEOUT_RESET;
        maint_limit = MAINTENANCE_TIMEOUT_RESET;
        light_st    = 1'b0;
        co2_st      = 1'b0;
        filter_st   = 1'b0;
        feeding_on  = 1'b0;
        maint_on    = 1'b0;
        feeding_t0  = '0;
        maint_t0    = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                cfg_write(plan[i].reg_index, plan[i].reg_value);
            else
                send_word(plan[i].func, plan[i].day, plan[i].now, plan[i].fixed, plan[i].want);
        end

        clock_now = $urandom;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  setting = SET_TYPICAL; end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  setting = SET_TYPICAL; end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; setting = SET_SHORT;   end
                3: begin send_idle_pct = 28; recv_stall_pct = 28; setting = SET_TYPICAL; end
                4: begin send_idle_pct = 0;  recv_stall_pct = 0;  setting = SET_EXTREME; end
                5: begin send_idle_pct = 28; recv_stall_pct = 28; setting = SET_NOISE;   end
                default:
                begin
                    send_idle_pct  = 48;
                    recv_stall_pct = 48;
                    setting        = SET_TYPICAL;
                end
            endcase

            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                case (setting)
                    SET_EXTREME:
                    begin
                        ea = {($urandom_range(0, 1) ? 17'h1FFFF : 17'h0), 1'($urandom_range(0, 1))};
                        eb = {($urandom_range(0, 1) ? 17'h1FFFF : 17'h0), 1'($urandom_range(0, 1))};
                    end
                    SET_NOISE:
                    begin
                        ea = ENTRY_W'($urandom);
                        eb = ENTRY_W'($urandom);
                    end
                    default:
                    begin
                        ta     = $urandom_range(0, DAY_LAST);
                        tb_end = $urandom_range(ta, DAY_LAST);
                        ea     = {17'(ta), 1'($urandom_range(0, 1))};
                        eb     = {17'(tb_end), 1'($urandom_range(0, 1))};
                    end
                endcase
                cfg_write(REG_ENTRY_BASE + REG_IDX_W'(ENTRY_SLOTS * ch), ea);
                cfg_write(REG_ENTRY_BASE + REG_IDX_W'(ENTRY_SLOTS * ch + 1), eb);
            end
            case (setting)
                SET_EXTREME:
                begin
                    cfg_write(REG_FEEDING_TIMEOUT, 18'd86400);
                    cfg_write(REG_MAINTENANCE_TIMEOUT, 18'd86400);
                end
                SET_SHORT:
                begin
                    cfg_write(REG_FEEDING_TIMEOUT, 18'd1);
                    cfg_write(REG_MAINTENANCE_TIMEOUT, 18'd1);
                end
                default:
                begin
                    cfg_write(REG_FEEDING_TIMEOUT, 18'($urandom_range(1, 600)));
                    cfg_write(REG_MAINTENANCE_TIMEOUT, 18'($urandom_range(1, 3000)));
                end
            endcase

            // Long receiver hold-off while the sender keeps offering words.
            if (setting == SET_EXTREME)
                holds_asked++;

            step_max = ((feed_limit > maint_limit) ? int'(feed_limit) : int'(maint_limit)) / 3 + 2;

            repeat (PHASE_WORDS)
            begin
                // Mostly small steps forward in time, with jumps onto the expiry boundary
                // of a running override and the odd leap anywhere in the stamp range.
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    clock_now = $urandom;
                else if (pick < 25 && feeding_on)
                    clock_now = feeding_t0 + NOW_W'(feed_limit) + $urandom_range(0, 2) - 32'd1;
                else if (pick < 25 && maint_on)
                    clock_now = maint_t0 + NOW_W'(maint_limit) + $urandom_range(0, 2) - 32'd1;
                else
                    clock_now = clock_now + $urandom_range(0, step_max);

                pick = $urandom_range(0, 99);
                if (pick < 80)
                    day = DAY_W'(clock_now % DAY_LENGTH);
                else if (pick < 90)
                    day = DAY_W'($urandom_range(0, DAY_LAST));
                else
                begin
                    // Land on or next to one of the programmed switching times.
                    tmp = int'(entry_word[$urandom_range(0, 2 * CHANNELS - 1)][ENTRY_W-1:1]);
                    tmp = tmp + int'($urandom_range(0, 2)) - 1;
                    if (tmp < 0)
                        tmp = 0;
                    if (tmp > DAY_LAST)
                        tmp = DAY_LAST;
                    day = DAY_W'(tmp);
                end

                pick = $urandom_range(0, 99);
                if (pick < 70)
                    f = FUNC_TICK;
                else if (pick < 85)
                    f = FUNC_FEEDING;
                else
                    f = FUNC_MAINTENANCE;

                send_word(f, day, clock_now, 1'b0, NO_STATUS);
            end
        end

        req_ch.valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
